// ===== rtl/core/ccsd_pkg.sv =====
// Shared types, widths and constants of the complex correlator sync detector.
`default_nettype none
package ccsd_pkg;

  localparam int DATA_W   = 16;           // real or imaginary part
  localparam int ENT_W    = 2 * DATA_W;   // packed {re, im} memory entry
  localparam int IDX_W    = 8;            // coefficient slot field
  localparam int THR_W    = 48;           // threshold and power
  localparam int CNT_W    = 16;           // sample counter and lock index
  localparam int PROD_W   = 2 * DATA_W;   // one real product
  localparam int FRAC_SH  = 16;           // floor shift applied to each tap term
  localparam int TERM_W   = PROD_W + 1 - FRAC_SH;
  localparam int TAPS_DEF = 256;

  localparam logic [THR_W-1:0] THR_RESET = 48'h0000_0006_9000;

  typedef enum logic [0:0] {
    ACT_COEF   = 1'b0,
    ACT_SAMPLE = 1'b1
  } ccsd_action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_SQ_RE,
    ST_SQ_IM,
    ST_SUM,
    ST_OUT
  } ccsd_state_e;

  // strobes from the sequencer to the datapath
  typedef struct packed {
    logic acc_clr;
    logic issue;
    logic live;
    logic sq_re;
    logic sq_im;
    logic sum;
    logic out_load;
  } ccsd_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/core/ccsd_if.sv =====
// Valid/ready channel interfaces for sample/coefficient items and results.
`default_nettype none
interface ccsd_in_if;
  logic                                valid;
  logic                                ready;
  logic                                action;
  logic        [ccsd_pkg::IDX_W-1:0]   tap_index;
  logic signed [ccsd_pkg::DATA_W-1:0]  real_part;
  logic signed [ccsd_pkg::DATA_W-1:0]  imag_part;

  modport source (output valid, action, tap_index, real_part, imag_part, input ready);
  modport sink   (input valid, action, tap_index, real_part, imag_part, output ready);
endinterface

interface ccsd_out_if;
  logic                        valid;
  logic                        ready;
  logic [ccsd_pkg::THR_W-1:0]  power;
  logic                        above_threshold;
  logic                        locked;
  logic [ccsd_pkg::CNT_W-1:0]  lock_index;

  modport source (output valid, power, above_threshold, locked, lock_index, input ready);
  modport sink   (input valid, power, above_threshold, locked, lock_index, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/ccsd_ctrl.sv =====
// Sequencer: tap walk, window pointers, fill count and result steps.
`default_nettype none
module ccsd_ctrl #(
  parameter int TAPS = ccsd_pkg::TAPS_DEF
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          smp_fire_i,
  input  wire                          out_room_i,
  output logic                         ready_o,
  output logic [$clog2(TAPS)-1:0]      win_waddr_o,
  output logic [$clog2(TAPS)-1:0]      win_raddr_o,
  output logic [$clog2(TAPS)-1:0]      coef_raddr_o,
  output ccsd_pkg::ccsd_ctl_t          ctl_o
);

  localparam int AW = $clog2(TAPS);
  localparam int FW = $clog2(TAPS + 1);
  localparam logic [AW-1:0] K_LAST   = AW'(TAPS - 1);
  localparam logic [FW-1:0] FILL_MAX = FW'(TAPS);

  ccsd_pkg::ccsd_state_e state_q, state_d;
  logic [AW-1:0] k_q, k_d;
  logic [AW-1:0] rptr_q, rptr_d;
  logic [AW-1:0] wptr_q, wptr_d;
  logic [FW-1:0] fill_q, fill_d;
  logic          drn_q, drn_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ccsd_pkg::ST_IDLE;
      k_q     <= '0;
      rptr_q  <= '0;
      wptr_q  <= '0;
      fill_q  <= '0;
      drn_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      rptr_q  <= rptr_d;
      wptr_q  <= wptr_d;
      fill_q  <= fill_d;
      drn_q   <= drn_d;
    end
  end

  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    rptr_d  = rptr_q;
    wptr_d  = wptr_q;
    fill_d  = fill_q;
    drn_d   = drn_q;
    ctl_o   = '0;
    case (state_q)
      ccsd_pkg::ST_IDLE: begin
        if (smp_fire_i) begin
          ctl_o.acc_clr = 1'b1;
          rptr_d        = wptr_q;   // newest sample lands here this cycle
          wptr_d        = (wptr_q == K_LAST) ? '0 : wptr_q + 1'b1;
          if (fill_q != FILL_MAX) begin
            fill_d = fill_q + 1'b1;
          end
          k_d     = '0;
          state_d = ccsd_pkg::ST_MAC;
        end
      end
      ccsd_pkg::ST_MAC: begin
        ctl_o.issue = 1'b1;
        // slots older than the number of pushed samples still read as zero
        ctl_o.live  = (FW'(k_q) < fill_q);
        k_d         = k_q + 1'b1;
        rptr_d      = (rptr_q == '0) ? K_LAST : rptr_q - 1'b1;
        if (k_q == K_LAST) begin
          drn_d   = 1'b0;
          state_d = ccsd_pkg::ST_DRAIN;
        end
      end
      ccsd_pkg::ST_DRAIN: begin
        // product stage, then the last accumulate
        drn_d = 1'b1;
        if (drn_q) begin
          state_d = ccsd_pkg::ST_SQ_RE;
        end
      end
      ccsd_pkg::ST_SQ_RE: begin
        ctl_o.sq_re = 1'b1;
        state_d     = ccsd_pkg::ST_SQ_IM;
      end
      ccsd_pkg::ST_SQ_IM: begin
        ctl_o.sq_im = 1'b1;
        state_d     = ccsd_pkg::ST_SUM;
      end
      ccsd_pkg::ST_SUM: begin
        ctl_o.sum = 1'b1;
        state_d   = ccsd_pkg::ST_OUT;
      end
      ccsd_pkg::ST_OUT: begin
        if (out_room_i) begin
          ctl_o.out_load = 1'b1;
          state_d        = ccsd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = ccsd_pkg::ST_IDLE;
      end
    endcase
  end

  assign ready_o      = (state_q == ccsd_pkg::ST_IDLE);
  assign win_waddr_o  = wptr_q;
  assign win_raddr_o  = rptr_q;
  assign coef_raddr_o = k_q;

endmodule
`default_nettype wire

// ===== rtl/core/ccsd_mac.sv =====
// Shared complex multiply-accumulate: one tap per cycle, pipelined products.
`default_nettype none
module ccsd_mac #(
  parameter int TAPS = ccsd_pkg::TAPS_DEF
) (
  input  wire                                                  clk_i,
  input  wire                                                  rst_ni,
  input  ccsd_pkg::ccsd_ctl_t                                  ctl_i,
  input  wire         [ccsd_pkg::ENT_W-1:0]                    win_rd_i,
  input  wire         [ccsd_pkg::ENT_W-1:0]                    coef_rd_i,
  output logic signed [ccsd_pkg::TERM_W+$clog2(TAPS)-1:0]      acc_re_o,
  output logic signed [ccsd_pkg::TERM_W+$clog2(TAPS)-1:0]      acc_im_o
);

  localparam int AW     = $clog2(TAPS);
  localparam int ACC_W  = ccsd_pkg::TERM_W + AW;
  localparam int DW     = ccsd_pkg::DATA_W;
  localparam int PW     = ccsd_pkg::PROD_W;
  localparam int TW     = ccsd_pkg::TERM_W;
  localparam int ENT_W_HI = ccsd_pkg::ENT_W - 1;

  logic v1_q, live1_q, v2_q;

  logic signed [DW-1:0] sr, si, cr, ci;
  logic signed [PW-1:0] p_rr_q, p_ii_q, p_ri_q, p_ir_q;
  logic signed [PW:0]   dre, dim;
  logic signed [TW-1:0] term_re, term_im;
  logic signed [ACC_W-1:0] acc_re_q, acc_im_q;

  // read data of the window and coefficient memories arrives in the cycle after issue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      live1_q <= 1'b0;
      v2_q    <= 1'b0;
    end else begin
      v1_q    <= ctl_i.issue;
      live1_q <= ctl_i.live;
      v2_q    <= v1_q;
    end
  end

  assign sr = live1_q ? signed'(win_rd_i[ENT_W_HI -: DW]) : '0;
  assign si = live1_q ? signed'(win_rd_i[DW-1:0])         : '0;
  assign cr = signed'(coef_rd_i[ENT_W_HI -: DW]);
  assign ci = signed'(coef_rd_i[DW-1:0]);

  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      p_rr_q <= sr * cr;
      p_ii_q <= si * ci;
      p_ri_q <= sr * ci;
      p_ir_q <= si * cr;
    end
  end

  // arithmetic shift right is the floor division by 2^16
  assign dre     = (PW+1)'(p_rr_q) - (PW+1)'(p_ii_q);
  assign dim     = (PW+1)'(p_ri_q) + (PW+1)'(p_ir_q);
  assign term_re = TW'(dre >>> ccsd_pkg::FRAC_SH);
  assign term_im = TW'(dim >>> ccsd_pkg::FRAC_SH);

  always_ff @(posedge clk_i) begin
    if (ctl_i.acc_clr) begin
      acc_re_q <= '0;
      acc_im_q <= '0;
    end else if (v2_q) begin
      acc_re_q <= acc_re_q + ACC_W'(term_re);
      acc_im_q <= acc_im_q + ACC_W'(term_im);
    end
  end

  assign acc_re_o = acc_re_q;
  assign acc_im_o = acc_im_q;

endmodule
`default_nettype wire

// ===== rtl/core/ccsd_power.sv =====
// Squared magnitude: one shared squarer for the real then the imaginary part, then sum and saturate.
`default_nettype none
module ccsd_power #(
  parameter int TAPS = ccsd_pkg::TAPS_DEF
) (
  input  wire                                              clk_i,
  input  ccsd_pkg::ccsd_ctl_t                              ctl_i,
  input  wire signed [ccsd_pkg::TERM_W+$clog2(TAPS)-1:0]   acc_re_i,
  input  wire signed [ccsd_pkg::TERM_W+$clog2(TAPS)-1:0]   acc_im_i,
  output logic       [ccsd_pkg::THR_W-1:0]                 power_o
);

  localparam int AW    = $clog2(TAPS);
  localparam int ACC_W = ccsd_pkg::TERM_W + AW;
  localparam int SQ_W  = 2 * ACC_W;
  localparam int SUM_W = SQ_W + 1;
  localparam int PW_W  = ccsd_pkg::THR_W;
  localparam int EXT_W = (SUM_W > PW_W) ? SUM_W : PW_W + 1;

  logic signed [ACC_W-1:0] op;
  logic        [ACC_W-1:0] mag;
  logic        [SQ_W-1:0]  sq;
  logic        [SQ_W-1:0]  sq_a_q, sq_b_q;
  logic        [EXT_W-1:0] sum;
  logic        [PW_W-1:0]  pow_q;

  assign op  = ctl_i.sq_im ? acc_im_i : acc_re_i;
  // magnitude of the most negative value still fits unsigned
  assign mag = op[ACC_W-1] ? ACC_W'(-op) : ACC_W'(op);
  assign sq  = SQ_W'(mag) * SQ_W'(mag);

  assign sum = EXT_W'(sq_a_q) + EXT_W'(sq_b_q);

  always_ff @(posedge clk_i) begin
    if (ctl_i.sq_re) begin
      sq_a_q <= sq;
    end
    if (ctl_i.sq_im) begin
      sq_b_q <= sq;
    end
    if (ctl_i.sum) begin
      pow_q <= (|sum[EXT_W-1:PW_W]) ? '1 : sum[PW_W-1:0];
    end
  end

  assign power_o = pow_q;

endmodule
`default_nettype wire

// ===== rtl/core/complex_correlator_sync_detect.sv =====
// Top level: complex matched-filter correlator with sync threshold and lock.
//
//   channel   dir  handshake            beat contents
//   item_i    in   valid/ready          action, tap_index, real_part, imag_part
//   res_o     out  valid/ready          power, above_threshold, locked, lock_index
//   cfg       in   cfg_we_i, no stall   cfg_wdata_i -> threshold
//
// A coefficient beat is written from idle and leaves the block ready. A sample beat
// keeps the block busy while the single complex MAC walks one tap per cycle through
// the one read port of the window and coefficient memories.
// Memories are not cleared at reset; the fill count makes unpushed window slots read
// as zero. A stalled result waits in the output register while the next beat is taken.
`default_nettype none
module complex_correlator_sync_detect #(
  parameter int TAPS = ccsd_pkg::TAPS_DEF
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  ccsd_in_if.sink                      item_i,
  ccsd_out_if.source                   res_o,
  input  wire                          cfg_we_i,
  input  wire [ccsd_pkg::THR_W-1:0]    cfg_wdata_i
);

  localparam int AW    = $clog2(TAPS);
  localparam int ACC_W = ccsd_pkg::TERM_W + AW;
  localparam int ENT_W = ccsd_pkg::ENT_W;
  localparam int CNT_W = ccsd_pkg::CNT_W;
  localparam int THR_W = ccsd_pkg::THR_W;

  ccsd_pkg::ccsd_ctl_t ctl;

  logic                 ready;
  logic                 fire, smp_fire, cof_fire;
  logic [AW-1:0]        win_waddr, win_raddr, coef_raddr;
  logic [AW+ccsd_pkg::IDX_W-1:0] tap_ext;
  logic [ENT_W-1:0]     win_mem  [TAPS];
  logic [ENT_W-1:0]     coef_mem [TAPS];
  logic [ENT_W-1:0]     win_rd_q, coef_rd_q;
  logic signed [ACC_W-1:0] acc_re, acc_im;
  logic [THR_W-1:0]     power;
  logic [THR_W-1:0]     thr_q;
  logic                 above;
  logic                 out_room;
  logic                 out_valid_q;
  logic [THR_W-1:0]     out_power_q;
  logic                 out_above_q, out_locked_q;
  logic [CNT_W-1:0]     out_idx_q;
  logic [CNT_W-1:0]     cnt_q;
  logic                 lock_q;
  logic [CNT_W-1:0]     lock_pos_q;

  assign item_i.ready = ready;
  assign fire     = item_i.valid && ready;
  assign smp_fire = fire && (item_i.action == ccsd_pkg::ACT_SAMPLE);
  assign cof_fire = fire && (item_i.action == ccsd_pkg::ACT_COEF)
                    && (32'(item_i.tap_index) < 32'(TAPS));
  assign tap_ext  = {{AW{1'b0}}, item_i.tap_index};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= ccsd_pkg::THR_RESET;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  // window and coefficient memories; writes happen only in idle, reads only in the tap walk
  always_ff @(posedge clk_i) begin
    if (smp_fire) begin
      win_mem[win_waddr] <= {item_i.real_part, item_i.imag_part};
    end
    if (ctl.issue) begin
      win_rd_q <= win_mem[win_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cof_fire) begin
      coef_mem[tap_ext[AW-1:0]] <= {item_i.real_part, item_i.imag_part};
    end
    if (ctl.issue) begin
      coef_rd_q <= coef_mem[coef_raddr];
    end
  end

  ccsd_ctrl #(.TAPS(TAPS)) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .smp_fire_i   (smp_fire),
    .out_room_i   (out_room),
    .ready_o      (ready),
    .win_waddr_o  (win_waddr),
    .win_raddr_o  (win_raddr),
    .coef_raddr_o (coef_raddr),
    .ctl_o        (ctl)
  );

  ccsd_mac #(.TAPS(TAPS)) u_mac (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (ctl),
    .win_rd_i  (win_rd_q),
    .coef_rd_i (coef_rd_q),
    .acc_re_o  (acc_re),
    .acc_im_o  (acc_im)
  );

  ccsd_power #(.TAPS(TAPS)) u_power (
    .clk_i    (clk_i),
    .ctl_i    (ctl),
    .acc_re_i (acc_re),
    .acc_im_i (acc_im),
    .power_o  (power)
  );

  assign above    = (power >= thr_q);
  assign out_room = !out_valid_q || res_o.ready;

  // lock state and sample count advance once per finished sample
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      lock_q     <= 1'b0;
      lock_pos_q <= '0;
    end else if (ctl.out_load) begin
      if (above && !lock_q) begin
        lock_q     <= 1'b1;
        lock_pos_q <= cnt_q;
      end
      if (cnt_q != '1) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.out_load) begin
      out_power_q  <= power;
      out_above_q  <= above;
      out_locked_q <= lock_q || above;
      out_idx_q    <= (above && !lock_q) ? cnt_q : lock_pos_q;
    end
  end

  assign res_o.valid           = out_valid_q;
  assign res_o.power           = out_power_q;
  assign res_o.above_threshold = out_above_q;
  assign res_o.locked          = out_locked_q;
  assign res_o.lock_index      = out_idx_q;

`ifndef ASSERT_OFF
  a_busy_after_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    smp_fire |=> !item_i.ready)
    else $error("sample beat taken but block still ready");

  a_lock_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lock_q |=> lock_q)
    else $error("lock flag dropped");

  a_lock_pos_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !lock_q |-> (lock_pos_q == '0))
    else $error("lock position moved before lock");

  a_cnt_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (cnt_q >= $past(cnt_q)))
    else $error("sample counter went backward");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.out_load |-> (!out_valid_q || res_o.ready))
    else $error("result register overwritten while held");
`endif

endmodule
`default_nettype wire
